>>> rtl/core/ini_tl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ini_tl_pkg;

  // Width of the line and column counters (8 to 32)
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned POS_OUT_BITS = 16;

  // Record slots per text byte (one byte fills three at most), and depth of the record queue
  localparam int unsigned MAX_RECS = 4;
  localparam int unsigned REC_IDX_BITS = $clog2(MAX_RECS);
  localparam int unsigned REC_CNT_BITS = $clog2(MAX_RECS + 1);
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = {POS_BITS{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  typedef enum logic [2:0] {
    RK_TOKEN    = 3'd0,
    RK_VALUE    = 3'd1,
    RK_END      = 3'd2,
    RK_BAD_CHAR = 3'd3,
    RK_UNTERM   = 3'd4
  } rec_kind_e;

  typedef enum logic [2:0] {
    TK_LBRACK = 3'd0,
    TK_RBRACK = 3'd1,
    TK_EQUALS = 3'd2,
    TK_COLON  = 3'd3,
    TK_IDENT  = 3'd4,
    TK_STRING = 3'd5,
    TK_EOF    = 3'd6,
    TK_NONE   = 3'd7
  } tok_kind_e;

  typedef struct packed {
    rec_kind_e               kind;
    tok_kind_e               tok;
    logic [7:0]              ch;
    logic                    first;
    logic [POS_OUT_BITS-1:0] line;
    logic [POS_OUT_BITS-1:0] col;
  } rec_t;

  // All records caused by one text byte, in order, plus the index of the last one
  typedef struct packed {
    rec_t [MAX_RECS-1:0]     recs;
    logic [REC_IDX_BITS-1:0] last_idx;
  } bundle_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [POS_OUT_BITS-1:0] clamp_pos(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? 16'hFFFF : w[POS_OUT_BITS-1:0];
  endfunction

  function automatic rec_t mk_rec(input rec_kind_e k, input tok_kind_e t,
                                  input logic [7:0] c, input logic f,
                                  input pos_t ln, input pos_t cl);
    rec_t r;
    r.kind  = k;
    r.tok   = t;
    r.ch    = c;
    r.first = f;
    r.line  = clamp_pos(ln);
    r.col   = clamp_pos(cl);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ini_tl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ini_tl_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [7:0]           text_byte_i,
  input  wire                  final_byte_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output ini_tl_pkg::bundle_t  bundle_o
);

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_IDENT    = 3'd1;
  localparam logic [2:0] M_STR_OPEN = 3'd2;
  localparam logic [2:0] M_STR      = 3'd3;
  localparam logic [2:0] M_COMMENT  = 3'd4;
  localparam logic [2:0] M_HALT     = 3'd5;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  logic [2:0]               mode_q, mode_d;
  ini_tl_pkg::pos_t         line_q, line_d;
  ini_tl_pkg::pos_t         col_q, col_d;
  ini_tl_pkg::pos_t         tsc_q, tsc_d;
  logic [ini_tl_pkg::REC_CNT_BITS-1:0] n_rec;
  ini_tl_pkg::bundle_t      bun;
  logic                     go_idle;
  logic                     is_space, is_alpha, is_ident;
  logic                     accept;
  ini_tl_pkg::tok_kind_e    punct;

  // Character classes
  assign is_space = (text_byte_i == 8'h20) || (text_byte_i inside {[8'h09:8'h0D]});
  assign is_alpha = text_byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign is_ident = is_alpha || (text_byte_i inside {[8'h30:8'h39]}) ||
                    (text_byte_i == CH_UNDER);

  always_comb begin
    case (text_byte_i)
      CH_LBRACK: punct = ini_tl_pkg::TK_LBRACK;
      CH_RBRACK: punct = ini_tl_pkg::TK_RBRACK;
      CH_EQUALS: punct = ini_tl_pkg::TK_EQUALS;
      CH_COLON:  punct = ini_tl_pkg::TK_COLON;
      default:   punct = ini_tl_pkg::TK_NONE;
    endcase
  end

  // Lex one byte: next state and the records it causes
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    tsc_d   = tsc_q;
    bun     = '0;
    n_rec   = '0;
    go_idle = 1'b0;

    case (mode_q)
      M_IDENT: begin
        if (is_ident) begin
          bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
            ini_tl_pkg::RK_VALUE, ini_tl_pkg::TK_IDENT, text_byte_i, 1'b0, line_d, col_d);
          n_rec = n_rec + 1'b1;
          col_d = ini_tl_pkg::sat_inc(col_d);
        end else begin
          bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
            ini_tl_pkg::RK_END, ini_tl_pkg::TK_IDENT, 8'd0, 1'b0, line_d, tsc_d);
          n_rec   = n_rec + 1'b1;
          go_idle = 1'b1;
        end
      end
      M_STR_OPEN, M_STR: begin
        if (text_byte_i == CH_QUOTE) begin
          bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
            ini_tl_pkg::RK_END, ini_tl_pkg::TK_STRING, 8'd0, 1'b0, line_d, tsc_d);
          n_rec  = n_rec + 1'b1;
          mode_d = M_IDLE;
          col_d  = ini_tl_pkg::sat_inc(col_d);
        end else if (text_byte_i == CH_LF) begin
          bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
            ini_tl_pkg::RK_UNTERM, ini_tl_pkg::TK_NONE, 8'd0, 1'b0, line_d, tsc_d);
          n_rec  = n_rec + 1'b1;
          mode_d = M_IDLE;
          line_d = ini_tl_pkg::sat_inc(line_d);
          col_d  = ini_tl_pkg::POS_ONE;
        end else begin
          bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
            ini_tl_pkg::RK_VALUE, ini_tl_pkg::TK_STRING, text_byte_i,
            mode_q == M_STR_OPEN, line_d, col_d);
          n_rec  = n_rec + 1'b1;
          mode_d = M_STR;
          col_d  = ini_tl_pkg::sat_inc(col_d);
        end
      end
      M_COMMENT: begin
        if (text_byte_i == CH_LF) begin
          mode_d = M_IDLE;
          line_d = ini_tl_pkg::sat_inc(line_d);
          col_d  = ini_tl_pkg::POS_ONE;
        end else begin
          col_d = ini_tl_pkg::sat_inc(col_d);
        end
      end
      M_HALT: begin
        mode_d = M_HALT;
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    // Byte seen in idle mode, also the byte that closed an identifier
    if (go_idle) begin
      mode_d = M_IDLE;
      if (text_byte_i == CH_LF) begin
        line_d = ini_tl_pkg::sat_inc(line_d);
        col_d  = ini_tl_pkg::POS_ONE;
      end else if (is_space) begin
        col_d = ini_tl_pkg::sat_inc(col_d);
      end else if (text_byte_i == CH_HASH) begin
        mode_d = M_COMMENT;
        col_d  = ini_tl_pkg::sat_inc(col_d);
      end else if (text_byte_i == CH_QUOTE) begin
        tsc_d  = col_d;
        mode_d = M_STR_OPEN;
        col_d  = ini_tl_pkg::sat_inc(col_d);
      end else if (is_alpha || (text_byte_i == CH_UNDER)) begin
        tsc_d = col_d;
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_VALUE, ini_tl_pkg::TK_IDENT, text_byte_i, 1'b1, line_d, col_d);
        n_rec  = n_rec + 1'b1;
        mode_d = M_IDENT;
        col_d  = ini_tl_pkg::sat_inc(col_d);
      end else if (punct != ini_tl_pkg::TK_NONE) begin
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_TOKEN, punct, 8'd0, 1'b0, line_d, col_d);
        n_rec = n_rec + 1'b1;
        col_d = ini_tl_pkg::sat_inc(col_d);
      end else begin
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_BAD_CHAR, ini_tl_pkg::TK_NONE, 8'd0, 1'b0, line_d, col_d);
        n_rec  = n_rec + 1'b1;
        mode_d = M_HALT;
        col_d  = ini_tl_pkg::sat_inc(col_d);
      end
    end

    // End of text: close any open token, add end of file unless halted, drop back to reset state
    if (final_byte_i) begin
      if (mode_d == M_IDENT) begin
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_END, ini_tl_pkg::TK_IDENT, 8'd0, 1'b0, line_d, tsc_d);
        n_rec = n_rec + 1'b1;
      end else if ((mode_d == M_STR_OPEN) || (mode_d == M_STR)) begin
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_UNTERM, ini_tl_pkg::TK_NONE, 8'd0, 1'b0, line_d, tsc_d);
        n_rec = n_rec + 1'b1;
      end
      if (mode_d != M_HALT) begin
        bun.recs[n_rec[ini_tl_pkg::REC_IDX_BITS-1:0]] = ini_tl_pkg::mk_rec(
          ini_tl_pkg::RK_TOKEN, ini_tl_pkg::TK_EOF, 8'd0, 1'b0, line_d, col_d);
        n_rec = n_rec + 1'b1;
      end
      mode_d = M_IDLE;
      line_d = ini_tl_pkg::POS_ONE;
      col_d  = ini_tl_pkg::POS_ONE;
      tsc_d  = ini_tl_pkg::POS_ONE;
    end

    bun.last_idx = ini_tl_pkg::REC_IDX_BITS'(n_rec - 1'b1);
  end

  // Take a byte whenever the queue has room; drop bytes that cause no record
  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept && (n_rec != '0);
  assign bundle_o   = bun;

  // Advance lexer state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= ini_tl_pkg::POS_ONE;
      col_q  <= ini_tl_pkg::POS_ONE;
      tsc_q  <= ini_tl_pkg::POS_ONE;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ini_tl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ini_tl_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ini_tl_pkg::bundle_t  push_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 not_empty_o,
  output ini_tl_pkg::bundle_t  head_o
);

  ini_tl_pkg::bundle_t                 mem_q [ini_tl_pkg::QDEPTH];
  logic [ini_tl_pkg::QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ini_tl_pkg::QCNT_BITS-1:0]    count_q;
  logic                                do_push, do_pop;

  assign full_o      = (count_q == ini_tl_pkg::QCNT_BITS'(ini_tl_pkg::QDEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Hold bundles in arrival order
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ini_tl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ini_tl_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_not_empty_i,
  input  ini_tl_pkg::bundle_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output ini_tl_pkg::rec_t     rec_o,
  output logic                 last_of_run_o
);

  logic [ini_tl_pkg::REC_IDX_BITS-1:0] idx_q;
  logic                                is_last;
  logic                                out_take;

  // Walk the head bundle one record per request
  assign out_valid_o   = q_not_empty_i;
  assign rec_o         = head_i.recs[idx_q];
  assign is_last       = (idx_q == head_i.last_idx);
  assign last_of_run_o = is_last;
  assign out_take      = out_valid_o && !out_stall_i;
  assign pop_o         = out_take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_take) begin
      idx_q <= is_last ? '0 : idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ini_style_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_stall_o   text_byte_i, final_byte_i
// output   out        out_valid_o / out_stall_i record_kind_o, token_kind_o, value_char_o,
//                                               first_of_token_o, line_no_o, column_no_o,
//                                               last_of_run_o
//
// The front lexes one text byte per cycle while the queue has room and writes all of its
// records (0 to 3) as one entry of a 4-deep queue; bytes that cause no record use no entry.
// The back sends one record per cycle while out_stall_i is low, walking each entry in order.
// in_stall_o rises only when the queue is full; out_stall_i holds the current record.
// Reset leaves the lexer idle at line 1, column 1, with the queue empty.
module ini_style_token_lexer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  text_byte_i,
  input  wire         final_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  value_char_o,
  output logic        first_of_token_o,
  output logic [15:0] line_no_o,
  output logic [15:0] column_no_o,
  output logic        last_of_run_o
);

  logic                 push, pop, q_full, q_not_empty;
  ini_tl_pkg::bundle_t  push_data, head;
  ini_tl_pkg::rec_t     rec;

  ini_tl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .bundle_o     (push_data)
  );

  ini_tl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .head_o      (head)
  );

  ini_tl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rec_o         (rec),
    .last_of_run_o (last_of_run_o)
  );

  // Split the record onto its ports
  assign record_kind_o    = rec.kind;
  assign token_kind_o     = rec.tok;
  assign value_char_o     = rec.ch;
  assign first_of_token_o = rec.first;
  assign line_no_o        = rec.line;
  assign column_no_o      = rec.col;

endmodule

`default_nettype wire
